@@ sv/bfcg_pkg.sv @@
// ----------------------------------------------------------------------------
// bfcg_pkg: shared types, font table and control program
// Glyph data, character lookup, row expansion and the sequencer microcode
// of the bitmap font character generator.
// ----------------------------------------------------------------------------
package bfcg_pkg;

	localparam int GLYPH_WIDTH  = 5;
	localparam int GLYPH_HEIGHT = 7;
	localparam int NUM_GLYPHS   = 39;
	localparam int MAX_SCALE    = 8;
	localparam int COORD_BITS   = 16;
	localparam int MASK_BITS    = GLYPH_WIDTH * MAX_SCALE;
	localparam int CFG_BITS     = 24;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_SCALE = 2'd0;
	localparam cfg_idx_t REG_COLOR = 2'd1;
	localparam cfg_idx_t REG_ALPHA = 2'd2;

	typedef logic [5:0] glyph_t;
	typedef logic [2:0] row_t;
	typedef logic [3:0] scale_t;
	typedef logic [GLYPH_WIDTH-1:0] bits_t;
	typedef logic [MASK_BITS-1:0] mask_t;

	localparam bits_t FONT [NUM_GLYPHS][GLYPH_HEIGHT] = '{
		'{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
		'{5'h0F,5'h10,5'h10,5'h10,5'h10,5'h10,5'h0F}, '{5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E},
		'{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F}, '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
		'{5'h0F,5'h10,5'h10,5'h13,5'h11,5'h11,5'h0F}, '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		'{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1F}, '{5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C},
		'{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
		'{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
		'{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
		'{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D}, '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
		'{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E}, '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		'{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}, '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
		'{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A}, '{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
		'{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
		'{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
		'{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, '{5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E},
		'{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, '{5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E},
		'{5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
		'{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E},
		'{5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C},
		'{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}
	};

	typedef struct packed {
		logic   valid;
		glyph_t idx;
	} glyph_sel_t;

	function automatic glyph_sel_t glyph_lookup(input logic [7:0] ch);
		logic [7:0] c;
		glyph_sel_t res;
		c = ch;
		res = '0;
		if (c inside {[8'h61:8'h7A]}) c = c - 8'h20;
		case (c) inside
			[8'h41:8'h5A]: res = '{1'b1, 6'(c - 8'h41)};
			[8'h30:8'h39]: res = '{1'b1, 6'(c - 8'h30 + 8'd26)};
			8'h3A:         res = '{1'b1, 6'd36};
			8'h2E:         res = '{1'b1, 6'd37};
			8'h2D:         res = '{1'b1, 6'd38};
			default:       res = '0;
		endcase
		return res;
	endfunction

	function automatic row_t last_lit_row(input glyph_t g);
		row_t res;
		res = '0;
		for (int r = 0; r < GLYPH_HEIGHT; r++) begin
			if (FONT[g][r] != '0) res = row_t'(r);
		end
		return res;
	endfunction

	function automatic mask_t expand_row(input bits_t b, input scale_t s);
		mask_t m;
		int idx;
		m = '0;
		for (int col = 0; col < GLYPH_WIDTH; col++) begin
			for (int k = 0; k < MAX_SCALE; k++) begin
				idx = col * int'(s) + k;
				if (k < int'(s) && b[GLYPH_WIDTH-1-col] && idx < MASK_BITS)
					m[6'(idx)] = 1'b1;
			end
		end
		return m;
	endfunction

	typedef enum logic [1:0] {
		ST_FETCH = 2'd0,
		ST_CHECK = 2'd1,
		ST_ROW   = 2'd2,
		ST_ADV   = 2'd3
	} step_t;

	typedef enum logic [2:0] {
		COND_NEVER    = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_NO_SCALE = 3'd2,
		COND_BLANK    = 3'd3,
		COND_MORE     = 3'd4
	} cond_t;

	typedef struct packed {
		logic  take;
		logic  emit;
		logic  adv;
		cond_t cond;
		step_t target;
	} ucode_t;

	localparam int NUM_STEPS = 4;

	localparam ucode_t UCODE [NUM_STEPS] = '{
		'{1'b1, 1'b0, 1'b0, COND_NO_SCALE, ST_FETCH},
		'{1'b0, 1'b0, 1'b0, COND_BLANK,    ST_ADV},
		'{1'b0, 1'b1, 1'b0, COND_MORE,     ST_ROW},
		'{1'b0, 1'b0, 1'b1, COND_ALWAYS,   ST_FETCH}
	};

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic no_scale;
		logic blank;
		logic row_empty;
		logic row_done;
	} bfcg_stat_t;

	typedef struct packed {
		logic in_rdy;
		logic emit;
		logic adv;
		logic go;
	} bfcg_ctl_t;

endpackage

@@ sv/bfcg_if.sv @@
// ----------------------------------------------------------------------------
// bfcg_if: request channels of the character generator
// Character request channel and span result channel, valid/ready.
// ----------------------------------------------------------------------------
interface bfcg_in_if;
	logic               valid;
	logic               ready;
	logic [7:0]         char_code;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic               string_start;

	modport source(output valid, char_code, origin_x, origin_y, string_start, input ready);
	modport sink(input valid, char_code, origin_x, origin_y, string_start, output ready);
endinterface

interface bfcg_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] span_x;
	logic signed [15:0] span_y;
	logic [39:0]        span_mask;
	logic [23:0]        span_color;
	logic [7:0]         span_alpha;
	logic               last_row;

	modport source(output valid, span_x, span_y, span_mask, span_color, span_alpha, last_row,
		input ready);
	modport sink(input valid, span_x, span_y, span_mask, span_color, span_alpha, last_row,
		output ready);
endinterface

@@ sv/bitmap_font_character_generator.sv @@
// ----------------------------------------------------------------------------
// bitmap_font_character_generator: 5x7 text character generator
// Draws characters at a running cursor as scaled pixel-row spans.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch, one character each; spans leave on out_ch, one
// per scaled pixel row that has lit pixels, top to bottom, last_row on the
// final span of the character. The cursor moves by six times scale, max 8.
// The cfg port (cfg_we, cfg_index, cfg_data) writes scale, color and alpha;
// write it only while no request is in flight.
// The sequencer works one request at a time through its fetch, check, row
// and advance steps; the row step handles one scaled row per cycle unless
// the output register is full, and skips an empty glyph row with no span.
// A blank character goes from the check straight to the advance, and a
// zero scale returns to fetch with no span. The first span is registered
// by the row step, after it has skipped each empty glyph row above it.
// A single output register holds each span; when the receiver stalls, the
// sequencer holds its row step and resumes when the register drains.
// Reset clears the cursor to 0, scale to 1, color to white, alpha to 255.
module bitmap_font_character_generator
	import bfcg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	bfcg_in_if.sink             in_ch,
	bfcg_out_if.source          out_ch,
	input  logic                cfg_we,
	input  cfg_idx_t            cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	scale_t      scale_q;
	logic [23:0] color_q;
	logic [7:0]  alpha_q;

	logic [COORD_BITS-1:0] cursor_q;
	logic [COORD_BITS-1:0] ycur_q;
	glyph_t                glyph_q;
	logic                  gvalid_q;
	scale_t                scl_q;
	row_t                  row_q;
	row_t                  sub_q;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q;
	logic [COORD_BITS-1:0] out_y_q;
	mask_t                 out_mask_q;
	logic [23:0]           out_color_q;
	logic [7:0]            out_alpha_q;
	logic                  out_last_q;

	bfcg_stat_t stat;
	bfcg_ctl_t  ctl;
	step_t      step;
	glyph_sel_t gsel;
	bits_t      row_bits;
	logic       row_empty;
	logic       sub_last;
	logic       accept;
	logic       row_go;
	logic       emit_fire;
	logic       out_free;

	bfcg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.step   (step)
	);

	always_comb begin
		gsel      = glyph_lookup(in_ch.char_code);
		row_bits  = FONT[glyph_q][row_q];
		row_empty = (row_bits == '0);
		sub_last  = (sub_q == row_t'(scl_q - 4'd1));
		out_free  = !out_valid_q || out_ch.ready;
		accept    = in_ch.valid && ctl.in_rdy;
		row_go    = ctl.emit && ctl.go;
		emit_fire = row_go && !row_empty;

		stat.in_valid  = in_ch.valid;
		stat.out_busy  = !out_free;
		stat.no_scale  = (scale_q == '0);
		stat.blank     = !gvalid_q;
		stat.row_empty = row_empty;
		stat.row_done  = (row_q == row_t'(GLYPH_HEIGHT - 1)) && (row_empty || sub_last);
	end

	assign in_ch.ready = ctl.in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 4'd1;
			color_q <= 24'hFFFFFF;
			alpha_q <= 8'hFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE: scale_q <= cfg_data[3:0];
				REG_COLOR: color_q <= cfg_data[23:0];
				REG_ALPHA: alpha_q <= cfg_data[7:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept && in_ch.string_start) begin
			cursor_q <= in_ch.origin_x;
		end else if (ctl.adv && ctl.go) begin
			cursor_q <= cursor_q + COORD_BITS'({scl_q, 2'b00}) + COORD_BITS'({scl_q, 1'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ycur_q   <= in_ch.origin_y;
			glyph_q  <= gsel.valid ? gsel.idx : '0;
			gvalid_q <= gsel.valid;
			scl_q    <= (scale_q > scale_t'(MAX_SCALE)) ? scale_t'(MAX_SCALE) : scale_q;
			row_q    <= '0;
			sub_q    <= '0;
		end else if (row_go) begin
			if (row_empty) begin
				ycur_q <= ycur_q + COORD_BITS'(scl_q);
				row_q  <= row_q + 3'd1;
				sub_q  <= '0;
			end else if (sub_last) begin
				ycur_q <= ycur_q + COORD_BITS'(1);
				row_q  <= row_q + 3'd1;
				sub_q  <= '0;
			end else begin
				ycur_q <= ycur_q + COORD_BITS'(1);
				sub_q  <= sub_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_x_q     <= cursor_q;
			out_y_q     <= ycur_q;
			out_mask_q  <= expand_row(row_bits, scl_q);
			out_color_q <= color_q;
			out_alpha_q <= alpha_q;
			out_last_q  <= sub_last && (row_q == last_lit_row(glyph_q));
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.span_x     = out_x_q;
	assign out_ch.span_y     = out_y_q;
	assign out_ch.span_mask  = out_mask_q;
	assign out_ch.span_color = out_color_q;
	assign out_ch.span_alpha = out_alpha_q;
	assign out_ch.last_row   = out_last_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> out_free)
		else $error("span written while output register full");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step == ST_ROW) |-> (scl_q != '0) && (scl_q <= scale_t'(MAX_SCALE))
			&& ({1'b0, sub_q} < scl_q))
		else $error("row step with sub-row outside scale");

	a_row_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(step == ST_ROW) |-> gvalid_q)
		else $error("row step entered for a blank character");

	a_ready_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scale_q != '0) |=> (step == ST_CHECK) && !out_last_q || (step == ST_CHECK))
		else $error("accepted request did not move to character check");

endmodule

@@ sv/bfcg_sequencer.sv @@
// ----------------------------------------------------------------------------
// bfcg_sequencer: microcoded control unit
// Step counter over the control program, with hold and conditional jumps.
// ----------------------------------------------------------------------------
module bfcg_sequencer
	import bfcg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  bfcg_stat_t stat,
	output bfcg_ctl_t  ctl,
	output step_t      step
);

	step_t  step_q;
	step_t  step_d;
	ucode_t uw;
	logic   hold;
	logic   taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		uw = UCODE[step_q];
		hold = (uw.take && !stat.in_valid) || (uw.emit && !stat.row_empty && stat.out_busy);
		case (uw.cond)
			COND_NEVER:    taken = 1'b0;
			COND_ALWAYS:   taken = 1'b1;
			COND_NO_SCALE: taken = stat.no_scale;
			COND_BLANK:    taken = stat.blank;
			COND_MORE:     taken = !stat.row_done;
			default:       taken = 1'b0;
		endcase
		if (hold) begin
			step_d = step_q;
		end else if (taken) begin
			step_d = uw.target;
		end else begin
			step_d = step_t'(step_q + 2'd1);
		end
		ctl.in_rdy = uw.take;
		ctl.emit   = uw.emit;
		ctl.adv    = uw.adv;
		ctl.go     = !hold;
	end

	assign step = step_q;

endmodule
